[hw/rtl/wtlp_pkg.sv]
// ----------------------------------------------------------------------------
// wtlp_pkg: shared types and constants for the wavetable playback block
// Widths of the fixed fields, register indexes and control structs.
// ----------------------------------------------------------------------------
package wtlp_pkg;

    localparam int WHOLE_BITS     = 24;   // integer part of the position
    localparam int STEP_BITS      = 4;    // remainder bits resolved per front stage
    localparam int NUM_STEPS      = WHOLE_BITS / STEP_BITS;
    localparam int LEN_BITS       = 13;
    localparam int REM_BITS       = LEN_BITS + 1;
    localparam int INDEX_BITS     = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam int QUEUE_DEPTH    = 8;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLAY_MODE    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TABLE_LENGTH = 1'd1;

    localparam logic [LEN_BITS-1:0] LENGTH_RESET = 13'd4096;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic MODE_PERIODIC = 1'b0;

    typedef struct packed {
        logic is_sample;
        logic active;
        logic wr_en;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[hw/rtl/wtlp_front.sv]
// ----------------------------------------------------------------------------
// wtlp_front: command intake and position reduction
// Pipelined restoring remainder of the integer position by the table length.
// ----------------------------------------------------------------------------
module wtlp_front #(
    parameter int TABLE_DEPTH = wtlp_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wtlp_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = wtlp_pkg::DEF_FRAC_BITS,
    localparam int ADDR_W     = $clog2(TABLE_DEPTH),
    localparam int POS_W      = wtlp_pkg::WHOLE_BITS + FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic                                  command,
    input  logic [wtlp_pkg::INDEX_BITS-1:0]       entry_index,
    input  logic signed [SAMPLE_BITS-1:0]         entry_left,
    input  logic signed [SAMPLE_BITS-1:0]         entry_right,
    input  logic [POS_W-1:0]                      position,
    input  logic [wtlp_pkg::REM_BITS-1:0]         len_eff,
    input  logic                                  play_mode,
    output logic                                  push,
    output wtlp_pkg::ctl_t                        push_ctl,
    output logic [ADDR_W-1:0]                     push_i0,
    output logic [ADDR_W-1:0]                     push_i1,
    output logic [FRAC_BITS-1:0]                  push_frac,
    output logic signed [SAMPLE_BITS-1:0]         push_left,
    output logic signed [SAMPLE_BITS-1:0]         push_right
);

    localparam int NST = wtlp_pkg::NUM_STEPS;
    localparam int RW  = wtlp_pkg::REM_BITS;
    localparam int WB  = wtlp_pkg::WHOLE_BITS;

    logic                             valid_reg [NST];
    wtlp_pkg::ctl_t                   ctl_reg   [NST];
    logic [RW-1:0]                    rem_reg   [NST];
    logic [WB-1:0]                    whole_reg [NST];
    logic [wtlp_pkg::INDEX_BITS-1:0]  idx_reg   [NST];
    logic [FRAC_BITS-1:0]             frac_reg  [NST];
    logic signed [SAMPLE_BITS-1:0]    left_reg  [NST];
    logic signed [SAMPLE_BITS-1:0]    right_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic                            valid_in;
        wtlp_pkg::ctl_t                  ctl_in;
        logic [RW-1:0]                   rem_in;
        logic [WB-1:0]                   whole_in;
        logic [wtlp_pkg::INDEX_BITS-1:0] idx_in;
        logic [FRAC_BITS-1:0]            frac_in;
        logic signed [SAMPLE_BITS-1:0]   left_in;
        logic signed [SAMPLE_BITS-1:0]   right_in;
        logic [RW-1:0]                   rem_next;
        logic [WB-1:0]                   whole_next;

        if (k == 0) begin : g_head
            logic [WB-1:0] whole_pos;
            assign whole_pos         = position[POS_W-1:FRAC_BITS];
            assign valid_in          = take;
            assign ctl_in.is_sample  = (command == wtlp_pkg::CMD_SAMPLE);
            assign ctl_in.active     = (play_mode == wtlp_pkg::MODE_PERIODIC) ||
                                       (whole_pos < WB'(len_eff));
            assign ctl_in.wr_en      = (command == wtlp_pkg::CMD_LOAD) &&
                                       (32'(entry_index) < TABLE_DEPTH);
            assign rem_in            = '0;
            assign whole_in          = whole_pos;
            assign idx_in            = entry_index;
            assign frac_in           = position[FRAC_BITS-1:0];
            assign left_in           = entry_left;
            assign right_in          = entry_right;
        end
        else begin : g_body
            assign valid_in = valid_reg[k-1];
            assign ctl_in   = ctl_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign whole_in = whole_reg[k-1];
            assign idx_in   = idx_reg[k-1];
            assign frac_in  = frac_reg[k-1];
            assign left_in  = left_reg[k-1];
            assign right_in = right_reg[k-1];
        end

        // r < len always holds, so each bit needs one compare and subtract
        always_comb
        begin
            rem_next   = rem_in;
            whole_next = whole_in;
            for (int j = 0; j < wtlp_pkg::STEP_BITS; j++)
            begin
                rem_next   = {rem_next[RW-2:0], whole_next[WB-1]};
                whole_next = {whole_next[WB-2:0], 1'b0};
                if (rem_next >= len_eff)
                begin
                    rem_next = rem_next - len_eff;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_reg[k]   <= ctl_in;
            rem_reg[k]   <= rem_next;
            whole_reg[k] <= whole_next;
            idx_reg[k]   <= idx_in;
            frac_reg[k]  <= frac_in;
            left_reg[k]  <= left_in;
            right_reg[k] <= right_in;
        end
    end

    logic [RW-1:0] rem_last;
    logic [RW-1:0] rem_inc;

    assign rem_last = rem_reg[NST-1];
    assign rem_inc  = rem_last + RW'(1);

    assign push       = valid_reg[NST-1];
    assign push_ctl   = ctl_reg[NST-1];
    assign push_i0    = ctl_reg[NST-1].is_sample ? ADDR_W'(rem_last)
                                                 : ADDR_W'(idx_reg[NST-1]);
    assign push_i1    = (rem_inc == len_eff) ? '0 : ADDR_W'(rem_inc);
    assign push_frac  = frac_reg[NST-1];
    assign push_left  = left_reg[NST-1];
    assign push_right = right_reg[NST-1];

endmodule

[hw/rtl/wtlp_queue.sv]
// ----------------------------------------------------------------------------
// wtlp_queue: short FIFO between front and back
// Register-array FIFO with show-ahead read.
// ----------------------------------------------------------------------------
module wtlp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wtlp_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        head_data,
    output wtlp_pkg::queue_status_t status
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/wtlp_back.sv]
// ----------------------------------------------------------------------------
// wtlp_back: table memory and linear interpolation
// Write/read of the stereo table, multiply, round, output register.
// ----------------------------------------------------------------------------
module wtlp_back #(
    parameter int TABLE_DEPTH = wtlp_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wtlp_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = wtlp_pkg::DEF_FRAC_BITS,
    localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  wtlp_pkg::ctl_t                head_ctl,
    input  logic [ADDR_W-1:0]             head_i0,
    input  logic [ADDR_W-1:0]             head_i1,
    input  logic [FRAC_BITS-1:0]          head_frac,
    input  logic signed [SAMPLE_BITS-1:0] head_left,
    input  logic signed [SAMPLE_BITS-1:0] head_right,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_sample,
    output logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          active
);

    localparam int S  = SAMPLE_BITS;
    localparam int PW = S + FRAC_BITS + 2;

    logic signed [S-1:0] tbl_left  [TABLE_DEPTH];
    logic signed [S-1:0] tbl_right [TABLE_DEPTH];

    logic                 adv;
    logic                 b1_valid_reg;
    logic                 b1_active_reg;
    logic [FRAC_BITS-1:0] b1_frac_reg;
    logic signed [S-1:0]  y0l_reg, y1l_reg, y0r_reg, y1r_reg;

    logic                 b2_valid_reg;
    logic                 b2_active_reg;
    logic signed [S-1:0]  b2_y0l_reg, b2_y0r_reg;
    logic signed [PW-1:0] prodl_reg, prodr_reg;

    logic                 out_valid_reg;
    logic                 out_active_reg;
    logic signed [S-1:0]  out_left_reg, out_right_reg;

    logic signed [S:0]         diffl, diffr;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PW-1:0]      prodl_next, prodr_next;
    logic signed [PW-1:0]      suml, sumr;
    logic signed [PW-1:0]      resl, resr;

    // whole back end moves together; holds while a result waits
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && head_valid;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pop && head_ctl.wr_en)
            begin
                tbl_left[head_i0]  <= head_left;
                tbl_right[head_i0] <= head_right;
            end
            y0l_reg <= tbl_left[head_i0];
            y1l_reg <= tbl_left[head_i1];
            y0r_reg <= tbl_right[head_i0];
            y1r_reg <= tbl_right[head_i1];
        end
    end

    assign diffl      = S'(0) + (S + 1)'(y1l_reg) - (S + 1)'(y0l_reg);
    assign diffr      = (S + 1)'(y1r_reg) - (S + 1)'(y0r_reg);
    assign frac_s     = $signed({1'b0, b1_frac_reg});
    assign prodl_next = diffl * frac_s;
    assign prodr_next = diffr * frac_s;

    // round half up, then floor shift
    assign suml = prodl_reg + (PW'(1) <<< (FRAC_BITS - 1));
    assign sumr = prodr_reg + (PW'(1) <<< (FRAC_BITS - 1));
    assign resl = PW'(b2_y0l_reg) + (suml >>> FRAC_BITS);
    assign resr = PW'(b2_y0r_reg) + (sumr >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= pop && head_ctl.is_sample;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_active_reg  <= head_ctl.active;
            b1_frac_reg    <= head_frac;
            b2_active_reg  <= b1_active_reg;
            b2_y0l_reg     <= y0l_reg;
            b2_y0r_reg     <= y0r_reg;
            prodl_reg      <= prodl_next;
            prodr_reg      <= prodr_next;
            out_active_reg <= b2_active_reg;
            out_left_reg   <= resl[S-1:0];
            out_right_reg  <= resr[S-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = out_left_reg;
    assign right_sample = out_right_reg;
    assign active       = out_active_reg;

endmodule

[hw/rtl/wavetable_linear_interp_playback.sv]
// ----------------------------------------------------------------------------
// wavetable_linear_interp_playback: stereo wavetable player
// Loads table entries and plays them back with linear interpolation.
// ----------------------------------------------------------------------------
// One beat enters per clock when the output side keeps up. A sample beat
// passes 6 front stages that reduce the 24-bit integer position modulo
// the table length, 4 bits per stage, then the queue, the registered table
// read, the multiply register and the round-and-add into the output
// register. A load beat travels the same path, writes the table when it
// reaches the memory and yields no output beat; because both kinds keep
// their order, a sample beat always sees every earlier load. The table has
// no reset and needs no clearing pass: reading an entry that was never
// loaded returns whatever the memory holds. in_ready drops only when 8
// beats are between the input and the memory stage, which happens only if
// the output is stalled. Configuration writes are accepted every cycle
// (cfg_ready is always high) and must only happen while the block is idle.
// table_length is clamped to the range 2 to TABLE_DEPTH; play_mode 0
// loops (active always set), 1 is one-shot (active while the integer
// position is below the length).
// ----------------------------------------------------------------------------
module wavetable_linear_interp_playback #(
    parameter int TABLE_DEPTH = wtlp_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = wtlp_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = wtlp_pkg::DEF_FRAC_BITS,
    localparam int POS_W      = wtlp_pkg::WHOLE_BITS + FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [wtlp_pkg::INDEX_BITS-1:0]     entry_index,
    input  logic signed [SAMPLE_BITS-1:0]       entry_left,
    input  logic signed [SAMPLE_BITS-1:0]       entry_right,
    input  logic [POS_W-1:0]                    position,
    // result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       left_sample,
    output logic signed [SAMPLE_BITS-1:0]       right_sample,
    output logic                                active,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wtlp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wtlp_pkg::LEN_BITS-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int QD     = wtlp_pkg::QUEUE_DEPTH;
    localparam int CW     = $clog2(QD + 1);
    localparam int CTL_W  = $bits(wtlp_pkg::ctl_t);
    localparam int QW     = CTL_W + 2 * ADDR_W + FRAC_BITS + 2 * SAMPLE_BITS;
    localparam int RW     = wtlp_pkg::REM_BITS;

    // configuration registers
    logic                          play_mode_reg;
    logic [wtlp_pkg::LEN_BITS-1:0] table_length_reg;
    logic [RW-1:0]                 len_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg    <= wtlp_pkg::MODE_PERIODIC;
            table_length_reg <= wtlp_pkg::LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wtlp_pkg::CFG_PLAY_MODE:    play_mode_reg    <= cfg_data[0];
                wtlp_pkg::CFG_TABLE_LENGTH: table_length_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // clamp to 2..TABLE_DEPTH; the result always fits the remainder width
    always_comb
    begin
        if (table_length_reg < wtlp_pkg::LEN_BITS'(2))
        begin
            len_eff = RW'(2);
        end
        else if (32'(table_length_reg) > TABLE_DEPTH)
        begin
            len_eff = RW'(TABLE_DEPTH);
        end
        else
        begin
            len_eff = RW'(table_length_reg);
        end
    end

    // credit count: beats accepted but not yet popped from the queue
    logic          take;
    logic          pop;
    logic [CW-1:0] in_flight_reg;
    logic [CW-1:0] in_flight_next;

    assign in_ready = (in_flight_reg < CW'(QD));
    assign take     = in_valid && in_ready;

    always_comb
    begin
        in_flight_next = in_flight_reg;
        if (take && !pop)
        begin
            in_flight_next = in_flight_reg + CW'(1);
        end
        else if (pop && !take)
        begin
            in_flight_next = in_flight_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    // front end
    logic                          push;
    wtlp_pkg::ctl_t                push_ctl;
    logic [ADDR_W-1:0]             push_i0, push_i1;
    logic [FRAC_BITS-1:0]          push_frac;
    logic signed [SAMPLE_BITS-1:0] push_left, push_right;

    wtlp_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .command     (command),
        .entry_index (entry_index),
        .entry_left  (entry_left),
        .entry_right (entry_right),
        .position    (position),
        .len_eff     (len_eff),
        .play_mode   (play_mode_reg),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_i0     (push_i0),
        .push_i1     (push_i1),
        .push_frac   (push_frac),
        .push_left   (push_left),
        .push_right  (push_right)
    );

    // queue between front and back
    logic [QW-1:0]           q_in, q_head;
    wtlp_pkg::queue_status_t q_status;

    wtlp_pkg::ctl_t                head_ctl;
    logic [ADDR_W-1:0]             head_i0, head_i1;
    logic [FRAC_BITS-1:0]          head_frac;
    logic signed [SAMPLE_BITS-1:0] head_left, head_right;

    assign q_in = {push_ctl, push_i0, push_i1, push_frac, push_left, push_right};
    assign {head_ctl, head_i0, head_i1, head_frac, head_left, head_right} = q_head;

    wtlp_queue #(
        .WIDTH (QW),
        .DEPTH (QD)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .head_data (q_head),
        .status    (q_status)
    );

    // back end
    wtlp_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_status.empty),
        .head_ctl     (head_ctl),
        .head_i0      (head_i0),
        .head_i1      (head_i1),
        .head_frac    (head_frac),
        .head_left    (head_left),
        .head_right   (head_right),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .active       (active)
    );

    // credits bound the queue: it can never overflow or underflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("queue pop while empty");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= CW'(QD))
        else $error("credit count above queue depth");

    a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty |-> (in_flight_reg != '0))
        else $error("queue holds beats not counted as credits");

endmodule
